### design/segment_sphere_intersection_assert.svh
// assertion macros shared by the segment / sphere intersection design
`ifndef SEGMENT_SPHERE_INTERSECTION_ASSERT_SVH
`define SEGMENT_SPHERE_INTERSECTION_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define SSI_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SSI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

### design/ssi_pkg.sv
// shared types and constants of the segment / sphere intersection pipeline
`default_nettype none
package ssi_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned RadiusW = 31;
	localparam int unsigned FracW = 17;
	localparam int unsigned UsedW = 2;
	localparam int unsigned DiscW = 136;
	localparam int unsigned RootW = 68;
	localparam int unsigned RemW = 70;
	localparam int unsigned BW = 68;
	localparam int unsigned TwoAW = 67;
	localparam int unsigned DivRemW = 68;
	localparam int unsigned SqrtCells = DiscW / 2;
	localparam int unsigned DivCells = FracW;
	localparam int unsigned InDataW = 320;
	localparam int unsigned OutDataW = 24;

	// which root of the quadratic was taken
	localparam logic [UsedW-1:0] ROOT_NONE = 2'd0;
	localparam logic [UsedW-1:0] ROOT_PLUS = 2'd1;
	localparam logic [UsedW-1:0] ROOT_MINUS = 2'd2;

	// one stage of the square root chain
	typedef struct packed {
		logic valid;
		logic [DiscW-1:0] disc;
		logic [RemW-1:0] rem;
		logic [RootW-1:0] root;
		logic signed [BW-1:0] b;
		logic [TwoAW-1:0] two_a;
		logic ok;
	} sqrt_stage_t;

	// one stage of the divider chain
	typedef struct packed {
		logic valid;
		logic [DivRemW-1:0] rem;
		logic [TwoAW-1:0] divisor;
		logic [FracW-1:0] quot;
		logic [UsedW-1:0] used;
	} div_stage_t;

endpackage
`default_nettype wire

### design/ssi_sqrt_cell.sv
// one bit step of the integer square root of the discriminant
`default_nettype none
module ssi_sqrt_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire ssi_pkg::sqrt_stage_t prev,
	output ssi_pkg::sqrt_stage_t next
);

	logic [ssi_pkg::RemW+1:0] cur;
	logic [ssi_pkg::RemW+1:0] trial;
	logic [ssi_pkg::RemW+1:0] diff;
	logic ge;
	ssi_pkg::sqrt_stage_t nxt;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		cur = {prev.rem, prev.disc[ssi_pkg::DiscW-1 -: 2]};
		trial = {2'b00, prev.root, 2'b01};
		diff = cur - trial;
		ge = (cur >= trial);
		nxt = prev;
		nxt.rem = ge ? diff[ssi_pkg::RemW-1:0] : cur[ssi_pkg::RemW-1:0];
		nxt.root = {prev.root[ssi_pkg::RootW-2:0], ge};
		nxt.disc = {prev.disc[ssi_pkg::DiscW-3:0], 2'b00};
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else if (en) begin
			next <= nxt;
		end
	end

endmodule
`default_nettype wire

### design/ssi_div_cell.sv
// one quotient bit of the fraction division
`default_nettype none
module ssi_div_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire ssi_pkg::div_stage_t prev,
	output ssi_pkg::div_stage_t next
);

	logic ge;
	logic [ssi_pkg::DivRemW-1:0] diff;
	ssi_pkg::div_stage_t nxt;

	// restoring step, remainder stays below the divisor before the shift
	always_comb begin
		ge = (prev.rem >= {1'b0, prev.divisor});
		diff = prev.rem - {1'b0, prev.divisor};
		nxt = prev;
		nxt.rem = ge ? {diff[ssi_pkg::DivRemW-2:0], 1'b0}
			: {prev.rem[ssi_pkg::DivRemW-2:0], 1'b0};
		nxt.quot = {prev.quot[ssi_pkg::FracW-2:0], ge};
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else if (en) begin
			next <= nxt;
		end
	end

endmodule
`default_nettype wire

### design/ssi_front.sv
// quadratic coefficients and discriminant, five pipeline stages
`default_nettype none
module ssi_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [ssi_pkg::RadiusW-1:0] radius,
	input wire logic signed [ssi_pkg::CoordW-1:0] centre [3],
	input wire logic signed [ssi_pkg::CoordW-1:0] start [3],
	input wire logic signed [ssi_pkg::CoordW-1:0] stop [3],
	output ssi_pkg::sqrt_stage_t out
);

	logic [3:0] valid_q;

	logic signed [32:0] d_s1 [3];
	logic signed [32:0] p_s1 [3];
	logic [30:0] r_s1;

	logic signed [65:0] dd_s2 [3];
	logic signed [65:0] dp_s2 [3];
	logic signed [65:0] pp_s2 [3];
	logic [61:0] rr_s2;

	logic signed [66:0] a_sum;
	logic signed [66:0] dp_sum;
	logic signed [66:0] pp_sum;
	logic signed [67:0] b_val;
	logic signed [67:0] c_val;
	logic [67:0] b_mag;
	logic [67:0] c_mag;

	logic [65:0] a_s3;
	logic signed [67:0] b_s3;
	logic [66:0] babs_s3;
	logic [66:0] cabs_s3;
	logic cneg_s3;

	logic [65:0] bhh_s4;
	logic [66:0] bhl_s4;
	logic [67:0] bll_s4;
	logic [64:0] ahch_s4;
	logic [65:0] ahcl_s4;
	logic [66:0] alch_s4;
	logic [67:0] alcl_s4;
	logic [65:0] a_s4;
	logic signed [67:0] b_s4;
	logic cneg_s4;

	logic [133:0] bb;
	logic [67:0] mid;
	logic [132:0] ac;
	logic [134:0] ac4;
	logic signed [135:0] disc;
	logic disc_ok;

	// valid bits of stages one to four, the fifth travels in out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[2:0], in_valid};
		end
	end

	// stage 1: direction and offset vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= $signed({stop[i][31], stop[i]}) - $signed({start[i][31], start[i]});
				p_s1[i] <= $signed({start[i][31], start[i]}) - $signed({centre[i][31], centre[i]});
			end
			r_s1 <= radius;
		end
	end

	// stage 2: component products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				dp_s2[i] <= d_s1[i] * p_s1[i];
				pp_s2[i] <= p_s1[i] * p_s1[i];
			end
			rr_s2 <= r_s1 * r_s1;
		end
	end

	// stage 3 logic: a, b, c and their magnitudes
	always_comb begin
		a_sum = 67'(dd_s2[0]) + 67'(dd_s2[1]) + 67'(dd_s2[2]);
		dp_sum = 67'(dp_s2[0]) + 67'(dp_s2[1]) + 67'(dp_s2[2]);
		pp_sum = 67'(pp_s2[0]) + 67'(pp_s2[1]) + 67'(pp_s2[2]);
		b_val = {dp_sum, 1'b0};
		c_val = 68'(pp_sum) - $signed({6'b0, rr_s2});
		b_mag = b_val[67] ? 68'(-b_val) : b_val;
		c_mag = c_val[67] ? 68'(-c_val) : c_val;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= a_sum[65:0];
			b_s3 <= b_val;
			babs_s3 <= b_mag[66:0];
			cabs_s3 <= c_mag[66:0];
			cneg_s3 <= c_val[67];
		end
	end

	// stage 4: partial products of b*b and a*|c|
	always_ff @(posedge clk) begin
		if (en) begin
			bhh_s4 <= babs_s3[66:34] * babs_s3[66:34];
			bhl_s4 <= babs_s3[66:34] * babs_s3[33:0];
			bll_s4 <= babs_s3[33:0] * babs_s3[33:0];
			ahch_s4 <= a_s3[65:34] * cabs_s3[66:34];
			ahcl_s4 <= a_s3[65:34] * cabs_s3[33:0];
			alch_s4 <= a_s3[33:0] * cabs_s3[66:34];
			alcl_s4 <= a_s3[33:0] * cabs_s3[33:0];
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			cneg_s4 <= cneg_s3;
		end
	end

	// stage 5 logic: discriminant b*b - 4*a*c
	always_comb begin
		bb = (134'(bhh_s4) << 68) + (134'(bhl_s4) << 35) + 134'(bll_s4);
		mid = 68'(ahcl_s4) + 68'(alch_s4);
		ac = (133'(ahch_s4) << 68) + (133'(mid) << 34) + 133'(alcl_s4);
		ac4 = {ac, 2'b00};
		disc = cneg_s4 ? ($signed({2'b00, bb}) + $signed({1'b0, ac4}))
			: ($signed({2'b00, bb}) - $signed({1'b0, ac4}));
		disc_ok = !disc[135] && (a_s4 != '0);
	end

	// stage 5 register, head of the square root chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out <= '0;
		end else if (en) begin
			out.valid <= valid_q[3];
			out.disc <= disc_ok ? disc : '0;
			out.rem <= '0;
			out.root <= '0;
			out.b <= b_s4;
			out.two_a <= {a_s4, 1'b0};
			out.ok <= disc_ok;
		end
	end

endmodule
`default_nettype wire

### design/segment_sphere_intersection.sv
// top level of the segment / sphere intersection pipeline
//
// one request on the slave stream carries a sphere (radius, centre) and a
// segment (start, end) in Q16.16; one result leaves on the master stream
// with the crossing fraction in Q1.16 and which root of the quadratic gave it
// results come out in request order, exactly one per request
// throughput: one request per cycle, with no gaps while the chain is not held
// pipeline: 92 register stages, the first loaded by the accepting edge:
// 5 stages of coefficient and discriminant arithmetic, 68 square root
// cells (one root bit each), one root select stage, 17 divider
// cells (one fraction bit each) and the
// output register
// the whole chain advances together; it holds only when a result sits in
// the output register unaccepted and another one has reached the chain end,
// so a waiting result does not stop new requests until the next result
// arrives behind it
// reset clears all valid bits; the first request may come the cycle after
// arst_n is released
`default_nettype none
module segment_sphere_intersection (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// radius[30:0], centre_x, centre_y, centre_z, start_x, start_y, start_z,
	// end_x, end_y, end_z (32 bits each), one zero pad bit
	input wire logic [ssi_pkg::InDataW-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// fraction[16:0], root_used[18:17], zero pad to 24 bits
	output logic [ssi_pkg::OutDataW-1:0] m_tdata
);

	`include "segment_sphere_intersection_assert.svh"

	logic en;
	logic signed [ssi_pkg::CoordW-1:0] centre [3];
	logic signed [ssi_pkg::CoordW-1:0] start [3];
	logic signed [ssi_pkg::CoordW-1:0] stop [3];

	ssi_pkg::sqrt_stage_t sq [ssi_pkg::SqrtCells+1];
	ssi_pkg::div_stage_t dv [ssi_pkg::DivCells+1];

	logic signed [ssi_pkg::BW:0] neg_b;
	logic signed [ssi_pkg::BW+1:0] n_plus;
	logic signed [ssi_pkg::BW+1:0] n_minus;
	logic signed [ssi_pkg::BW+1:0] lim;
	logic fit_plus;
	logic fit_minus;
	ssi_pkg::div_stage_t sel;

	logic out_valid_q;
	logic [ssi_pkg::FracW-1:0] fraction_q;
	logic [ssi_pkg::UsedW-1:0] root_used_q;

	// chain advance: hold only when the output is full and another result waits
	assign en = !(dv[ssi_pkg::DivCells].valid && out_valid_q && !m_tready);
	assign s_tready = en;

	// unpack the request
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			centre[i] = s_tdata[31 + 32*i +: 32];
			start[i] = s_tdata[127 + 32*i +: 32];
			stop[i] = s_tdata[223 + 32*i +: 32];
		end
	end

	ssi_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_tvalid),
		.radius(s_tdata[ssi_pkg::RadiusW-1:0]),
		.centre(centre),
		.start(start),
		.stop(stop),
		.out(sq[0])
	);

	// square root chain
	for (genvar g = 0; g < ssi_pkg::SqrtCells; g++) begin : g_sqrt
		ssi_sqrt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev(sq[g]),
			.next(sq[g+1])
		);
	end

	// root select: plus root first, then minus root, each within [0, 2a]
	always_comb begin
		neg_b = -$signed({sq[ssi_pkg::SqrtCells].b[ssi_pkg::BW-1], sq[ssi_pkg::SqrtCells].b});
		n_plus = (ssi_pkg::BW+2)'(neg_b) + $signed({2'b00, sq[ssi_pkg::SqrtCells].root});
		n_minus = (ssi_pkg::BW+2)'(neg_b) - $signed({2'b00, sq[ssi_pkg::SqrtCells].root});
		lim = $signed({3'b000, sq[ssi_pkg::SqrtCells].two_a});
		fit_plus = sq[ssi_pkg::SqrtCells].ok && !n_plus[ssi_pkg::BW+1] && (n_plus <= lim);
		fit_minus = sq[ssi_pkg::SqrtCells].ok && !n_minus[ssi_pkg::BW+1] && (n_minus <= lim);
		sel.valid = sq[ssi_pkg::SqrtCells].valid;
		sel.divisor = sq[ssi_pkg::SqrtCells].two_a;
		sel.quot = '0;
		if (fit_plus) begin
			sel.rem = n_plus[ssi_pkg::DivRemW-1:0];
			sel.used = ssi_pkg::ROOT_PLUS;
		end else if (fit_minus) begin
			sel.rem = n_minus[ssi_pkg::DivRemW-1:0];
			sel.used = ssi_pkg::ROOT_MINUS;
		end else begin
			sel.rem = '0;
			sel.used = ssi_pkg::ROOT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= '0;
		end else if (en) begin
			dv[0] <= sel;
		end
	end

	// divider chain
	for (genvar g = 0; g < ssi_pkg::DivCells; g++) begin : g_div
		ssi_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev(dv[g]),
			.next(dv[g+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (en && dv[ssi_pkg::DivCells].valid) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && dv[ssi_pkg::DivCells].valid) begin
			root_used_q <= dv[ssi_pkg::DivCells].used;
			fraction_q <= (dv[ssi_pkg::DivCells].used == ssi_pkg::ROOT_NONE) ? '0
				: dv[ssi_pkg::DivCells].quot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'b0, root_used_q, fraction_q};

	// checks
	`SSI_ASSERT_IMPLY(a_no_root_zero, clk, arst_n, out_valid_q && root_used_q == ssi_pkg::ROOT_NONE, fraction_q == '0)
	`SSI_ASSERT_IMPLY(a_used_code, clk, arst_n, out_valid_q, root_used_q != 2'd3)
	`SSI_ASSERT_IMPLY(a_frac_range, clk, arst_n, out_valid_q, fraction_q <= 17'd65536)
	`SSI_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, out_valid_q && !m_tready && dv[ssi_pkg::DivCells].valid, !en)

endmodule
`default_nettype wire
